// ----- rtl/aes_pkg.sv -----
// Package for the AES-128 CBC block: S-box tables and byte-level helper functions.
// It has no dependencies; every module in rtl/ imports it.
`default_nettype none
package aes_pkg;

  localparam int RoundCount = 10;
  localparam int RoundW = 4;

  localparam logic [2:0] CfgKeyHigh = 3'd0;
  localparam logic [2:0] CfgKeyLow = 3'd1;
  localparam logic [2:0] CfgIvHigh = 3'd2;
  localparam logic [2:0] CfgIvLow = 3'd3;
  localparam logic [2:0] CfgDirection = 3'd4;

  localparam logic [7:0] Poly = 8'h1b;

  localparam logic [7:0] FwdBox [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] BackBox [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       load;
    logic       decrypt;
    logic       first_round;
    logic       last_round;
  } rnd_ctrl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? Poly : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24];
    a1 = c[23:16];
    a2 = c[15:8];
    a3 = c[7:0];
    mix_col[31:24] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
    mix_col[23:16] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
    mix_col[15:8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
    mix_col[7:0]   = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
  endfunction

  // Inverse mix as a pre-step (multiply by 4,5 pattern) followed by the forward mix.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] u, v;
    logic [31:0] p;
    u = xtime(xtime(c[31:24] ^ c[15:8]));
    v = xtime(xtime(c[23:16] ^ c[7:0]));
    p = {c[31:24] ^ u, c[23:16] ^ v, c[15:8] ^ u, c[7:0] ^ v};
    inv_mix_col = mix_col(p);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/aes_key_exp.sv -----
// Key expansion unit: derives one round key per cycle and stores it in two 11 x 64 memories (high and low halves).
// Depends on aes_pkg for the forward S-box and xtime.
`default_nettype none
module aes_key_exp
  import aes_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [127:0]        key,
  input  wire logic [RoundW-1:0]   rd_round,
  output logic      [127:0]        rd_key,
  output logic                     busy
);

  logic [63:0]        mem_hi [RoundCount+1];
  logic [63:0]        mem_lo [RoundCount+1];
  logic [127:0]       cur_r;
  logic [7:0]         rcon_r;
  logic [RoundW-1:0]  cnt_r;
  logic               busy_r;
  logic [127:0]       nxt_key;
  logic [31:0]        t;
  logic [31:0]        w0, w1, w2, w3;
  logic               wr_en;
  logic [RoundW-1:0]  wr_idx;
  logic [127:0]       wr_data;

  always_comb begin
    t  = {FwdBox[cur_r[23:16]] ^ rcon_r, FwdBox[cur_r[15:8]],
          FwdBox[cur_r[7:0]], FwdBox[cur_r[31:24]]};
    w0 = cur_r[127:96] ^ t;
    w1 = cur_r[95:64] ^ w0;
    w2 = cur_r[63:32] ^ w1;
    w3 = cur_r[31:0] ^ w2;
    nxt_key = {w0, w1, w2, w3};
    wr_en   = start || busy_r;
    wr_idx  = start ? '0 : cnt_r;
    wr_data = start ? key : nxt_key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= RoundW'(1);
    end else if (busy_r) begin
      cnt_r <= cnt_r + RoundW'(1);
      if (cnt_r == RoundW'(RoundCount)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur_r  <= key;
      rcon_r <= 8'h01;
    end else if (busy_r) begin
      cur_r  <= nxt_key;
      rcon_r <= xtime(rcon_r);
    end
    if (wr_en) begin
      mem_hi[wr_idx] <= wr_data[127:64];
      mem_lo[wr_idx] <= wr_data[63:0];
    end
    rd_key <= {mem_hi[rd_round], mem_lo[rd_round]};
  end

  assign busy = busy_r;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("key expansion restarted while busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0 && cnt_r <= RoundW'(RoundCount)))
    else $error("key expansion counter out of range");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == RoundW'(RoundCount)) |=> !busy_r)
    else $error("key expansion did not finish");
`endif

endmodule
`default_nettype wire

// ----- rtl/aes_round.sv -----
// Shared AES round unit: one forward or inverse round on the 128-bit state per cycle while step is high.
// Depends on aes_pkg for the S-boxes, mix functions and the control struct.
`default_nettype none
module aes_round
  import aes_pkg::*;
(
  input  wire logic         clk,
  input  wire rnd_ctrl_t    ctrl,
  input  wire logic         step,
  input  wire logic [127:0] load_data,
  input  wire logic [127:0] round_key,
  output logic      [127:0] state
);

  logic [127:0] state_r;
  logic [127:0] state_nxt;
  logic [127:0] sb;
  logic [127:0] mixed;
  logic [127:0] keyed;

  // Byte b sits at bits [127-8b -: 8]; byte r+4c is row r, column c.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctrl.decrypt) begin
          sb[127 - 8*(r + 4*((c + r) % 4)) -: 8] = BackBox[state_r[127 - 8*(r + 4*c) -: 8]];
        end else begin
          sb[127 - 8*(r + 4*c) -: 8] = FwdBox[state_r[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
        end
      end
    end
    keyed = sb ^ round_key;
    for (int c = 0; c < 4; c++) begin
      if (ctrl.decrypt) begin
        mixed[127 - 32*c -: 32] = inv_mix_col(keyed[127 - 32*c -: 32]);
      end else begin
        mixed[127 - 32*c -: 32] = mix_col(sb[127 - 32*c -: 32]) ^ round_key[127 - 32*c -: 32];
      end
    end
    if (ctrl.load) begin
      state_nxt = load_data;
    end else if (ctrl.first_round) begin
      state_nxt = state_r ^ round_key;
    end else if (ctrl.last_round) begin
      state_nxt = keyed;
    end else begin
      state_nxt = mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule
`default_nettype wire

// ----- rtl/aes128_cbc_cipher.sv -----
// AES-128 CBC cipher top level: configuration registers, chaining and the round sequencer.
// Depends on aes_pkg, aes_key_exp and aes_round.
//
// Usage: write key, IV and direction through the cfg_ port while idle (index 0 key high,
// 1 key low, 2 IV high, 3 IV low, 4 direction). Each request on the in_ channel carries one
// 128-bit block; first_block restarts the chain from the IV. One result per request appears
// on the out_ channel and is held until out_ready is seen.
// Steps from acceptance to out_valid: StKey checks the round keys, StLoad loads the block and
// fetches the first round key, then StRun does the initial key addition and ten rounds in the
// shared round unit. After any key write the first request waits in StKey for key expansion,
// one round key per cycle. One request is in flight at a time; in_ready returns the cycle after
// the result has been taken, so no request is accepted while one is pending. A stalled receiver
// holds the block. Reset clears the chain value, the configuration and the key-valid flag.
`default_nettype none
module aes128_cbc_cipher
  import aes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_data_high,
  input  wire logic [63:0] in_data_low,
  input  wire logic        in_first_block,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] out_result_high,
  output logic      [63:0] out_result_low
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StKey  = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StRun  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]        st_r, st_nxt;
  logic [127:0]      key_r, iv_r, chain_r, din_r;
  logic              dir_r, keys_ok_r, first_r;
  logic [RoundW-1:0] rnd_r;
  logic [127:0]      out_word;
  logic              kx_start, kx_busy;
  logic [RoundW-1:0] rd_round;
  logic [127:0]      rd_key;
  logic [127:0]      state;
  logic [127:0]      chain_use;
  rnd_ctrl_t         ctrl;
  logic              step;
  logic              accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (st_r == StIdle);
  assign out_valid = (st_r == StOut);
  assign chain_use = first_r ? iv_r : chain_r;
  assign out_word  = dir_r ? (state ^ chain_use) : state;
  assign out_result_high = out_word[127:64];
  assign out_result_low  = out_word[63:0];
  assign kx_start  = (st_r == StKey) && !kx_busy && !keys_ok_r;

  // rnd_r counts key-addition steps 0..RoundCount; each key is fetched in the cycle before its step.
  always_comb begin
    case (st_r)
      StLoad:  rd_round = dir_r ? RoundW'(RoundCount) : '0;
      StRun:   rd_round = dir_r ? RoundW'(RoundCount) - rnd_r - RoundW'(1) : rnd_r + RoundW'(1);
      default: rd_round = '0;
    endcase
  end

  always_comb begin
    ctrl.load        = (st_r == StLoad);
    ctrl.decrypt     = dir_r;
    ctrl.first_round = (rnd_r == '0);
    ctrl.last_round  = (rnd_r == RoundW'(RoundCount));
    step             = (st_r == StLoad) || (st_r == StRun);
  end

  aes_key_exp u_kx (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kx_start),
    .key      (key_r),
    .rd_round (rd_round),
    .rd_key   (rd_key),
    .busy     (kx_busy)
  );

  aes_round u_rnd (
    .clk       (clk),
    .ctrl      (ctrl),
    .step      (step),
    .load_data (dir_r ? din_r : (din_r ^ chain_use)),
    .round_key (rd_key),
    .state     (state)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      StIdle:  if (accept) st_nxt = StKey;
      StKey:   if (keys_ok_r && !kx_busy) st_nxt = StLoad;
      StLoad:  st_nxt = StRun;
      StRun:   if (rnd_r == RoundW'(RoundCount)) st_nxt = StOut;
      StOut:   if (out_ready) st_nxt = StIdle;
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= StIdle;
      key_r     <= '0;
      iv_r      <= '0;
      dir_r     <= 1'b0;
      chain_r   <= '0;
      keys_ok_r <= 1'b0;
      rnd_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if (kx_start) begin
        keys_ok_r <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CfgKeyHigh: begin
            key_r[127:64] <= cfg_data;
            keys_ok_r     <= 1'b0;
          end
          CfgKeyLow: begin
            key_r[63:0] <= cfg_data;
            keys_ok_r   <= 1'b0;
          end
          CfgIvHigh:    iv_r[127:64] <= cfg_data;
          CfgIvLow:     iv_r[63:0]   <= cfg_data;
          CfgDirection: dir_r        <= cfg_data[0];
          default: ;
        endcase
      end
      if (st_r == StLoad) begin
        rnd_r <= '0;
      end else if (st_r == StRun) begin
        rnd_r <= rnd_r + RoundW'(1);
      end
      if (st_r == StOut && out_ready) begin
        chain_r <= dir_r ? din_r : state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      din_r   <= {in_data_high, in_data_low};
      first_r <= in_first_block;
    end
  end

`ifndef SYNTHESIS
  a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while result pending");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == StRun && rnd_r == RoundW'(RoundCount)) |=> out_valid)
    else $error("result not presented after last round");
  a_keys_first: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == StLoad) |-> (keys_ok_r && !kx_busy))
    else $error("rounds started without expanded keys");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_result_high) && $stable(out_result_low)))
    else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire
